/* rtl/lpr_pkg.sv */
package lpr_pkg;

  localparam int SCREEN_SIZE = 64;
  localparam int COORD_W     = 6;
  localparam int COLOUR_W    = 2;
  localparam int CNT_W       = $clog2(SCREEN_SIZE);
  localparam int ERR_W       = COORD_W + 3;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [COLOUR_W-1:0] colour_t;

  typedef struct packed {
    logic load;
    logic emit;
  } lpr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic stop;
  } lpr_stat_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } lpr_state_t;

  function automatic coord_t clamp_coord(input coord_t v);
    coord_t r;
    r = v;
    if (int'(v) > SCREEN_SIZE - 1) begin
      r = COORD_W'(SCREEN_SIZE - 1);
    end
    return r;
  endfunction

endpackage

/* rtl/lpr_ctrl.sv */
module lpr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  lpr_pkg::lpr_stat_t stat,
  output lpr_pkg::lpr_cmd_t  cmd
);

  lpr_pkg::lpr_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      lpr_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = lpr_pkg::S_RUN;
        end
      end
      lpr_pkg::S_RUN: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.stop) begin
            state_nxt = lpr_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lpr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_load_to_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == lpr_pkg::S_RUN)
    else $error("load did not start a line");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free && !in_tready)
    else $error("emit while output busy or idle");
`endif

endmodule

/* rtl/lpr_dp.sv */
module lpr_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lpr_pkg::lpr_cmd_t        cmd,
  output lpr_pkg::lpr_stat_t       stat,
  input  logic                     use_last_end,
  input  lpr_pkg::coord_t          start_x,
  input  lpr_pkg::coord_t          start_y,
  input  lpr_pkg::coord_t          end_x,
  input  lpr_pkg::coord_t          end_y,
  input  logic                     cfg_we,
  input  lpr_pkg::colour_t         cfg_wdata,
  output logic                     out_valid,
  input  logic                     out_ready,
  output lpr_pkg::coord_t          pixel_x,
  output lpr_pkg::coord_t          pixel_y,
  output lpr_pkg::colour_t         pixel_tag,
  output logic                     last_pixel
);

  lpr_pkg::colour_t colour_r;
  lpr_pkg::coord_t  prev_x_r, prev_y_r;
  lpr_pkg::coord_t  x_r, y_r, x1_r, y1_r, dx_r, dy_r;
  logic             sx_neg_r, sy_neg_r;
  logic signed [lpr_pkg::ERR_W-1:0] err_r, err_nxt;
  logic [lpr_pkg::CNT_W-1:0] cnt_r;

  logic             out_valid_r;
  lpr_pkg::coord_t  pix_x_r, pix_y_r;
  lpr_pkg::colour_t pix_tag_r;
  logic             pix_last_r;

  lpr_pkg::coord_t  x0, y0, xe, ye;
  lpr_pkg::coord_t  x_nxt, y_nxt;
  logic signed [lpr_pkg::ERR_W:0] e2, dx_s, dy_s;
  logic             step_x, step_y, at_end, cnt_full;

  assign x0 = use_last_end ? lpr_pkg::clamp_coord(prev_x_r) : lpr_pkg::clamp_coord(start_x);
  assign y0 = use_last_end ? lpr_pkg::clamp_coord(prev_y_r) : lpr_pkg::clamp_coord(start_y);
  assign xe = lpr_pkg::clamp_coord(end_x);
  assign ye = lpr_pkg::clamp_coord(end_y);

  assign dx_s   = $signed({{(lpr_pkg::ERR_W + 1 - lpr_pkg::COORD_W){1'b0}}, dx_r});
  assign dy_s   = $signed({{(lpr_pkg::ERR_W + 1 - lpr_pkg::COORD_W){1'b0}}, dy_r});
  assign e2     = {err_r, 1'b0};
  assign step_x = e2 > -dy_s;
  assign step_y = e2 < dx_s;

  always_comb begin
    err_nxt = err_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    if (step_x) begin
      err_nxt = err_nxt - lpr_pkg::ERR_W'(dy_s);
      x_nxt   = sx_neg_r ? x_r - 1'b1 : x_r + 1'b1;
    end
    if (step_y) begin
      err_nxt = err_nxt + lpr_pkg::ERR_W'(dx_s);
      y_nxt   = sy_neg_r ? y_r - 1'b1 : y_r + 1'b1;
    end
  end

  assign at_end        = (x_r == x1_r) && (y_r == y1_r);
  assign cnt_full      = cnt_r == lpr_pkg::CNT_W'(lpr_pkg::SCREEN_SIZE - 1);
  assign stat.stop     = at_end || cnt_full;
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colour_r <= '0;
    end else if (cfg_we) begin
      colour_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
    end else if (cmd.load) begin
      prev_x_r <= xe;
      prev_y_r <= ye;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r      <= x0;
      y_r      <= y0;
      x1_r     <= xe;
      y1_r     <= ye;
      dx_r     <= (xe > x0) ? xe - x0 : x0 - xe;
      dy_r     <= (ye > y0) ? ye - y0 : y0 - ye;
      sx_neg_r <= !(x0 < xe);
      sy_neg_r <= !(y0 < ye);
      err_r    <= lpr_pkg::ERR_W'(((xe > x0) ? xe - x0 : x0 - xe))
                - lpr_pkg::ERR_W'(((ye > y0) ? ye - y0 : y0 - ye));
      cnt_r    <= '0;
    end else if (cmd.emit) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pix_x_r    <= x_r;
      pix_y_r    <= y_r;
      pix_tag_r  <= colour_r;
      pix_last_r <= at_end;
    end
  end

  assign out_valid  = out_valid_r;
  assign pixel_x    = pix_x_r;
  assign pixel_y    = pix_y_r;
  assign pixel_tag  = pix_tag_r;
  assign last_pixel = pix_last_r;

`ifndef SYNTH
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && at_end |=> out_valid_r && pix_last_r)
    else $error("endpoint beat without last flag");

  a_load_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cnt_r == '0 && x1_r == $past(xe) && y1_r == $past(ye))
    else $error("line setup wrong");
`endif

endmodule

/* rtl/line_pixel_rasterizer_unit.sv */
// Bresenham line rasterizer for a 64x64 screen. Each input beat requests one
// line, from (start_x, start_y) or, with tuser set, from the end of the
// previous line, to (end_x, end_y); the block then sends one output beat per
// pixel in drawing order, tlast marking the endpoint. The end point is kept
// for the next request. Each line begins with a setup step in the idle state,
// then the single stepping unit sends one pixel per cycle while the output
// is free; output stalls hold the stepper. The next request is taken as soon
// as the last pixel sits in the output register. cfg_wdata sets the colour
// tag copied into every pixel; write it only while idle.
module line_pixel_rasterizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // start_x, start_y, end_x, end_y
  input  logic        in_tuser,   // use_last_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // pixel_x, pixel_y, pixel_tag, zero pad
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  lpr_pkg::lpr_cmd_t  cmd;
  lpr_pkg::lpr_stat_t stat;
  lpr_pkg::coord_t    pixel_x, pixel_y;
  lpr_pkg::colour_t   pixel_tag;

  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .use_last_end (in_tuser),
    .start_x      (in_tdata[5:0]),
    .start_y      (in_tdata[11:6]),
    .end_x        (in_tdata[17:12]),
    .end_y        (in_tdata[23:18]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_tag    (pixel_tag),
    .last_pixel   (out_tlast)
  );

  assign out_tdata = {2'b00, pixel_tag, pixel_y, pixel_x};

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    lpr_pkg::coord_t  x;
    lpr_pkg::coord_t  y;
    lpr_pkg::colour_t tag;
    logic             last;
  } pixel_t;

  class pixel_scoreboard;
    lpr_pkg::colour_t colour;
    lpr_pkg::coord_t  last_x;
    lpr_pkg::coord_t  last_y;
    int               errors;
    pixel_t           pending_pixels[$];

    function new();
      colour = '0;
      last_x = '0;
      last_y = '0;
      errors = 0;
    endfunction

    function int sat(input int v);
      return (v > lpr_pkg::SCREEN_SIZE - 1) ? lpr_pkg::SCREEN_SIZE - 1 : v;
    endfunction

    // Bresenham walk, one expected pixel per step
    function void note_line(input bit from_prev,
                            input lpr_pkg::coord_t sx_in, input lpr_pkg::coord_t sy_in,
                            input lpr_pkg::coord_t ex_in, input lpr_pkg::coord_t ey_in);
      int x, y, x1, y1, dx, dy, stx, sty, err, e2, n;
      bit done;
      pixel_t p;
      x  = sat(from_prev ? int'(last_x) : int'(sx_in));
      y  = sat(from_prev ? int'(last_y) : int'(sy_in));
      x1 = sat(int'(ex_in));
      y1 = sat(int'(ey_in));
      dx = (x1 > x) ? x1 - x : x - x1;
      dy = (y1 > y) ? y1 - y : y - y1;
      stx = (x < x1) ? 1 : -1;
      sty = (y < y1) ? 1 : -1;
      err = dx - dy;
      n = 0;
      while (n < lpr_pkg::SCREEN_SIZE) begin
        done = (x == x1) && (y == y1);
        p.x = lpr_pkg::coord_t'(x);
        p.y = lpr_pkg::coord_t'(y);
        p.tag = colour;
        p.last = done;
        pending_pixels.push_back(p);
        n++;
        if (done) break;
        e2 = err * 2;
        if (e2 > -dy) begin
          err -= dy;
          x += stx;
        end
        if (e2 < dx) begin
          err += dx;
          y += sty;
        end
      end
      last_x = lpr_pkg::coord_t'(x1);
      last_y = lpr_pkg::coord_t'(y1);
    endfunction

    function void check_pixel(input lpr_pkg::coord_t x, input lpr_pkg::coord_t y,
                              input lpr_pkg::colour_t tag, input logic last);
      pixel_t e;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d tag=%0d last=%0b", x, y, tag, last);
        errors++;
        return;
      end
      e = pending_pixels.pop_front();
      if (x !== e.x) begin
        $error("pixel_x expected %0d actual %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("pixel_y expected %0d actual %0d", e.y, y);
        errors++;
      end
      if (tag !== e.tag) begin
        $error("pixel_tag expected %0d actual %0d", e.tag, tag);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_pixel expected %0b actual %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // start_x, start_y, end_x, end_y
  logic        in_tuser;   // use_last_end
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // pixel_x, pixel_y, pixel_tag, zero pad
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;

  pixel_scoreboard sb;
  bit steady;
  bit hold_req;

  line_pixel_rasterizer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[line_pixel_rasterizer_unit] ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sink side
  initial begin
    int stall_left;
    int g;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_pixel(out_tdata[5:0], out_tdata[11:6], out_tdata[13:12], out_tlast);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 250;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        g = pick_gap();
        stall_left = (g > 0) ? g - 1 : 0;
        out_tready <= (g == 0);
      end
    end
  end

  task automatic send_line(input bit from_prev,
                           input lpr_pkg::coord_t sx, input lpr_pkg::coord_t sy,
                           input lpr_pkg::coord_t ex, input lpr_pkg::coord_t ey);
    int g;
    g = steady ? 0 : pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= from_prev;
    in_tdata  <= {ey, ex, sy, sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_line(from_prev, sx, sy, ex, ey);
  endtask

  task automatic send_random();
    int kind;
    bit from_prev;
    lpr_pkg::coord_t a, b, c, d;
    kind = $urandom_range(0, 99);
    a = lpr_pkg::coord_t'($urandom);
    b = lpr_pkg::coord_t'($urandom);
    c = lpr_pkg::coord_t'($urandom);
    d = lpr_pkg::coord_t'($urandom);
    from_prev = (kind < 30);
    if (kind >= 30 && kind < 40) begin
      c = a;
      d = b;
    end else if (kind >= 40 && kind < 55) begin
      c = $urandom_range(0, 1) ? lpr_pkg::coord_t'(63) : lpr_pkg::coord_t'(0);
      d = $urandom_range(0, 1) ? lpr_pkg::coord_t'(63) : lpr_pkg::coord_t'(0);
    end else if (kind >= 55 && kind < 75) begin
      c = a + lpr_pkg::coord_t'($urandom_range(0, 6)) - lpr_pkg::coord_t'(3);
      d = b + lpr_pkg::coord_t'($urandom_range(0, 6)) - lpr_pkg::coord_t'(3);
    end
    send_line(from_prev, a, b, c, d);
  endtask

  task automatic wait_lines_done();
    in_tvalid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_colour(input lpr_pkg::colour_t c);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.colour = c;
  endtask

  initial begin
    sb = new();
    steady = 1'b0;
    hold_req = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: stored end after reset, corners, axes, steep/shallow, single points
    send_line(1'b1, 6'd17, 6'd42, 6'd0,  6'd0);
    send_line(1'b0, 6'd0,  6'd0,  6'd63, 6'd63);
    send_line(1'b0, 6'd63, 6'd63, 6'd0,  6'd0);
    send_line(1'b0, 6'd0,  6'd63, 6'd63, 6'd0);
    send_line(1'b0, 6'd63, 6'd0,  6'd0,  6'd63);
    send_line(1'b0, 6'd0,  6'd5,  6'd63, 6'd5);
    send_line(1'b0, 6'd63, 6'd5,  6'd0,  6'd5);
    send_line(1'b0, 6'd7,  6'd0,  6'd7,  6'd63);
    send_line(1'b0, 6'd7,  6'd63, 6'd7,  6'd0);
    send_line(1'b0, 6'd10, 6'd0,  6'd13, 6'd63);
    send_line(1'b0, 6'd0,  6'd10, 6'd63, 6'd13);
    send_line(1'b0, 6'd31, 6'd31, 6'd31, 6'd31);
    send_line(1'b1, 6'd0,  6'd0,  6'd40, 6'd2);
    send_line(1'b1, 6'd63, 6'd63, 6'd40, 6'd2);
    send_line(1'b1, 6'd63, 6'd63, 6'd0,  6'd63);
    send_line(1'b0, 6'd63, 6'd63, 6'd63, 6'd63);
    send_line(1'b0, 6'd2,  6'd60, 6'd61, 6'd1);
    wait_lines_done();

    set_colour(2'd3);
    steady = 1'b1;
    repeat (15) send_random();
    wait_lines_done();
    steady = 1'b0;

    // sink holds off while lines keep coming
    set_colour(2'd1);
    hold_req = 1'b1;
    repeat (6) send_line(1'b0, 6'd0, 6'd0, lpr_pkg::coord_t'($urandom_range(40, 63)), 6'd20);
    repeat (25) send_random();
    wait_lines_done();

    set_colour(2'd2);
    repeat (30) send_random();
    wait_lines_done();

    set_colour(2'd0);
    repeat (17) send_random();
    wait_lines_done();

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[line_pixel_rasterizer_unit] OK");
    end else begin
      $display("[line_pixel_rasterizer_unit] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lpr_pkg.sv
rtl/lpr_ctrl.sv
rtl/lpr_dp.sv
rtl/line_pixel_rasterizer_unit.sv
tb/tb_top.sv
